// ===== design/hwb_pkg.sv =====
// Shared constants, codes and types of the hashed word blacklist.
package hwb_pkg;

	localparam int TABLE_ENTRIES = 10;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int HASH_W = 32;
	localparam int SLOT_W = 4;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [HASH_W-1:0] SEED_RESET = 32'd31;

	typedef enum logic [1:0] {
		MODE_QUERY  = 2'd0,
		MODE_ADD    = 2'd1,
		MODE_DELETE = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]        mode;
		logic [HASH_W-1:0] word_hash;
	} word_op_t;

endpackage

// ===== design/hwb_if.sv =====
// Channel interfaces: character input, result output and seed configuration.
interface hwb_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [7:0] char_byte;
	logic       end_of_word;

	modport source (output valid, output mode, output char_byte, output end_of_word,
		input ready);
	modport sink (input valid, input mode, input char_byte, input end_of_word,
		output ready);
endinterface

interface hwb_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic        was_listed;
	logic [3:0]  slot_index;
	logic [31:0] word_hash;

	modport source (output valid, output status, output was_listed, output slot_index,
		output word_hash, input ready);
	modport sink (input valid, input status, input was_listed, input slot_index,
		input word_hash, output ready);
endinterface

interface hwb_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] hash_seed;

	modport source (output valid, output hash_seed, input ready);
	modport sink (input valid, input hash_seed, output ready);
endinterface

// ===== design/hwb_front.sv =====
// Front end: holds the seed, folds characters into the hash and issues word operations.
module hwb_front (
	input  logic             clk,
	input  logic             arst_n,
	hwb_in_if.sink           chars,
	hwb_cfg_if.sink          cfg,
	input  logic             q_full,
	output logic             q_push,
	output hwb_pkg::word_op_t q_data
);

	logic [hwb_pkg::HASH_W-1:0] seed_q;
	logic [hwb_pkg::HASH_W-1:0] acc_q;
	logic [hwb_pkg::HASH_W-1:0] acc_next;
	logic                       accept;

	assign cfg.ready = 1'b1;
	assign chars.ready = !q_full;
	assign accept = chars.valid && chars.ready;
	assign acc_next = acc_q * seed_q + {24'd0, chars.char_byte};

	assign q_push = accept && chars.end_of_word;
	assign q_data.mode = chars.mode;
	assign q_data.word_hash = acc_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= hwb_pkg::SEED_RESET;
		end else if (cfg.valid) begin
			seed_q <= cfg.hash_seed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (accept) begin
			acc_q <= chars.end_of_word ? '0 : acc_next;
		end
	end

endmodule

// ===== design/hwb_queue.sv =====
// Short queue of word operations between the front and the back end.
module hwb_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  hwb_pkg::word_op_t push_data,
	output logic              full,
	output logic              pop_valid,
	input  logic              pop,
	output hwb_pkg::word_op_t pop_data
);

	hwb_pkg::word_op_t            mem_q [hwb_pkg::QUEUE_DEPTH];
	logic [hwb_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [hwb_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [hwb_pkg::QCNT_W-1:0]   count_q;
	logic                         do_pop;

	assign full = (count_q == hwb_pkg::QCNT_W'(hwb_pkg::QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign do_pop = pop && pop_valid;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= (wr_ptr_q == hwb_pkg::QPTR_W'(hwb_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == hwb_pkg::QPTR_W'(hwb_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			case ({push && !full, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/hwb_back.sv =====
// Back end: applies query, add or delete to the slot table and registers the result.
module hwb_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              op_valid,
	input  hwb_pkg::word_op_t op,
	output logic              op_pop,
	hwb_out_if.source         results
);

	logic [hwb_pkg::HASH_W-1:0] slots_q [hwb_pkg::TABLE_ENTRIES];
	logic                       out_valid_q;
	hwb_pkg::status_t           status_q;
	logic                       listed_q;
	logic [hwb_pkg::SLOT_W-1:0] slot_q;
	logic [hwb_pkg::HASH_W-1:0] hash_q;

	logic                       hit;
	logic [hwb_pkg::IDX_W-1:0]  hit_idx;
	logic                       has_free;
	logic [hwb_pkg::IDX_W-1:0]  free_idx;
	logic                       wr_en;
	logic [hwb_pkg::IDX_W-1:0]  wr_idx;
	logic [hwb_pkg::HASH_W-1:0] wr_data;
	hwb_pkg::status_t           status_d;
	logic [hwb_pkg::IDX_W-1:0]  slot_d;

	assign op_pop = op_valid && (!out_valid_q || results.ready);

	always_comb begin
		hit = 1'b0;
		hit_idx = '0;
		has_free = 1'b0;
		free_idx = '0;
		for (int i = hwb_pkg::TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (slots_q[i] == op.word_hash) begin
				hit = 1'b1;
				hit_idx = hwb_pkg::IDX_W'(i);
			end
			if (slots_q[i] == '0) begin
				has_free = 1'b1;
				free_idx = hwb_pkg::IDX_W'(i);
			end
		end
	end

	always_comb begin
		wr_en = 1'b0;
		wr_idx = hit_idx;
		wr_data = '0;
		status_d = hwb_pkg::ST_DONE;
		slot_d = hit ? hit_idx : '0;
		case (op.mode)
			hwb_pkg::MODE_ADD: begin
				if (!hit) begin
					if (has_free) begin
						wr_en = 1'b1;
						wr_idx = free_idx;
						wr_data = op.word_hash;
						slot_d = free_idx;
					end else begin
						status_d = hwb_pkg::ST_FULL;
					end
				end
			end
			hwb_pkg::MODE_DELETE: begin
				if (hit) begin
					wr_en = 1'b1;
				end else begin
					status_d = hwb_pkg::ST_NOT_FOUND;
				end
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < hwb_pkg::TABLE_ENTRIES; i++) begin
				slots_q[i] <= '0;
			end
		end else if (op_pop && wr_en) begin
			slots_q[wr_idx] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (op_pop) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (op_pop) begin
			status_q <= status_d;
			listed_q <= hit;
			slot_q <= hwb_pkg::SLOT_W'(slot_d);
			hash_q <= op.word_hash;
		end
	end

	assign results.valid = out_valid_q;
	assign results.status = status_q;
	assign results.was_listed = listed_q;
	assign results.slot_index = slot_q;
	assign results.word_hash = hash_q;

endmodule

// ===== design/hashed_word_blacklist_core.sv =====
// Top level of the hashed word blacklist: front end, operation queue and table back end.
//
//   channel   role    beat carries
//   chars     sink    mode, char_byte, end_of_word
//   results   source  status, was_listed, slot_index, word_hash
//   cfg       sink    hash_seed
//
// One char beat per cycle unless the queue is full; hash multiply-add is the only loop.
// After its last character beat a word waits in the queue, then its result is registered
// once that register is free; the table operation runs as the word leaves the queue.
// Reset clears the seed to 31, the hash and all table slots at once; no clearing pass.
// A stalled result holds the table; chars stalls only when the two-entry queue is full.
module hashed_word_blacklist_core (
	input  logic       clk,
	input  logic       arst_n,
	hwb_in_if.sink     chars,
	hwb_out_if.source  results,
	hwb_cfg_if.sink    cfg
);

	logic              q_full;
	logic              q_push;
	hwb_pkg::word_op_t q_in;
	logic              q_valid;
	logic              q_pop;
	hwb_pkg::word_op_t q_out;

	hwb_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.cfg    (cfg),
		.q_full (q_full),
		.q_push (q_push),
		.q_data (q_in)
	);

	hwb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop_valid (q_valid),
		.pop       (q_pop),
		.pop_data  (q_out)
	);

	hwb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (q_valid),
		.op       (q_out),
		.op_pop   (q_pop),
		.results  (results)
	);

endmodule
